### sv/vlid_pkg.sv
// ----------------------------------------------------------------------------
// vlid_pkg
// Shared types, constants and the opcode table of the instruction decoder.
// ----------------------------------------------------------------------------
package vlid_pkg;

	typedef enum logic [1:0] {
		KIND_OPERAND = 2'd0,
		KIND_BRANCH  = 2'd1,
		KIND_END     = 2'd2,
		KIND_UNDEF   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PH_OPC  = 2'd0,
		PH_SPEC = 2'd1,
		PH_EXT  = 2'd2,
		PH_BR   = 2'd3
	} phase_t;

	localparam logic [5:0] MAX_LEN   = 6'h3F;
	localparam logic [3:0] REG_PC    = 4'd15;
	localparam logic [3:0] MODE_INDEX = 4'd4;
	localparam logic [3:0] MODE_IMM   = 4'd8;
	localparam logic [3:0] MODE_ABS   = 4'd9;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] instr_addr;
		logic [7:0]  opcode;
		logic [2:0]  operand_index;
		logic [3:0]  spec_mode;
		logic [3:0]  base_reg;
		logic        index_used;
		logic [3:0]  index_reg;
		logic [31:0] value;
		logic        value_is_address;
		logic [5:0]  length;
		logic        last;
	} rec_t;

	// Entry: bit 7 defined, bits 2:0 operand count, bits 4:3 size code,
	// bits 6:5 branch displacement bytes.
	localparam logic [7:0] OPTAB [256] = '{
		8'h90,8'h90,8'h90,8'h90,8'h90,8'h90,8'h00,8'h00,
		8'h00,8'h00,8'h96,8'h00,8'h83,8'h83,8'h82,8'h82,
		8'hB0,8'hB0,8'hB0,8'hB0,8'hB0,8'hB0,8'h81,8'h81,
		8'hB0,8'hB0,8'hB0,8'hB0,8'hB0,8'hB0,8'hB0,8'hB0,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h83,8'h83,8'h84,8'h84,8'h85,8'h85,8'h86,8'h86,
		8'hD0,8'hD0,8'h8A,8'h8A,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h84,8'h83,8'h83,8'h8A,8'hCB,8'h8A,8'h89,
		8'h92,8'h93,8'h92,8'h93,8'h92,8'h93,8'h92,8'h93,
		8'h92,8'h92,8'h92,8'h92,8'h82,8'h8A,8'h92,8'hD3,
		8'h92,8'h92,8'h92,8'h91,8'h95,8'h93,8'h92,8'h00,
		8'h8A,8'h00,8'h00,8'h00,8'h82,8'h82,8'h9A,8'h9A,
		8'h9A,8'h9B,8'h9A,8'h9B,8'h9A,8'h9B,8'h9A,8'h9B,
		8'h9A,8'h9A,8'h9A,8'h9A,8'h82,8'h8A,8'h92,8'hDB,
		8'h9A,8'h9A,8'h9A,8'h99,8'h9D,8'h9B,8'h9A,8'h00,
		8'h93,8'h9B,8'h94,8'h94,8'h99,8'h9A,8'h9A,8'h99,
		8'h82,8'h83,8'h82,8'h83,8'h82,8'h83,8'h82,8'h83,
		8'h82,8'h83,8'h82,8'h83,8'h82,8'h83,8'h82,8'h83,
		8'h82,8'h82,8'h82,8'h82,8'h81,8'h81,8'h81,8'h81,
		8'h82,8'h82,8'h82,8'h82,8'h93,8'hC3,8'h82,8'h81,
		8'h8A,8'h8B,8'h8A,8'h8B,8'h8A,8'h8B,8'h8A,8'h8B,
		8'h8A,8'h8B,8'h8A,8'h8B,8'h8A,8'h8B,8'h8A,8'h8B,
		8'h8A,8'h8A,8'h8A,8'h8A,8'h89,8'h89,8'h89,8'h89,
		8'h89,8'h89,8'h89,8'h89,8'h89,8'h89,8'h89,8'h89,
		8'h92,8'h93,8'h92,8'h93,8'h92,8'h93,8'h92,8'h93,
		8'h92,8'h93,8'h92,8'h93,8'h92,8'h93,8'h92,8'h93,
		8'h92,8'h92,8'h92,8'h92,8'h91,8'h91,8'h91,8'h91,
		8'h92,8'h92,8'h00,8'h00,8'h91,8'h91,8'h92,8'h91,
		8'hB2,8'hB2,8'hB2,8'hB2,8'hB2,8'hB2,8'hB2,8'hB2,
		8'hB1,8'hB1,8'h94,8'h94,8'h94,8'h94,8'h94,8'h94,
		8'h94,8'hD3,8'hB2,8'hB2,8'hB1,8'hB1,8'h92,8'h92,
		8'h00,8'h00,8'h92,8'h92,8'h90,8'h00,8'h00,8'h00
	};

	// Number of extension bytes that follow a base specifier.
	function automatic logic [3:0] ext_len(input logic [3:0] mode, input logic [3:0] rg,
		input logic [1:0] size_code);
		logic [3:0] len;
		begin
			case (mode)
				4'd8:         len = (rg == REG_PC) ? (4'd1 << size_code) : 4'd0;
				4'd9:         len = (rg == REG_PC) ? 4'd4 : 4'd0;
				4'd10, 4'd11: len = 4'd1;
				4'd12, 4'd13: len = 4'd2;
				4'd14, 4'd15: len = 4'd4;
				default:      len = 4'd0;
			endcase
			return len;
		end
	endfunction

endpackage

### sv/vlid_parse.sv
// ----------------------------------------------------------------------------
// vlid_parse
// Parse state and combinational record generation for each byte transfer.
// ----------------------------------------------------------------------------
module vlid_parse #(
	parameter int ADDR_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             acc,
	input  logic [7:0]       code_byte,
	input  logic [31:0]      byte_addr,
	input  logic             restart,
	output vlid_pkg::rec_t   rec0,
	output vlid_pkg::rec_t   rec1,
	output logic [1:0]       nrec
);
	import vlid_pkg::*;

	localparam int AW = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;

	logic [AW-1:0] start_q, start_d;
	logic [7:0]    opc_q, opc_d;
	phase_t        phase_q, phase_d;
	logic [2:0]    ol_q, ol_d, pos_q, pos_d;
	logic [3:0]    fbl_q, fbl_d;
	logic [31:0]   acc_q, acc_d;
	logic [3:0]    hm_q, hm_d, hr_q, hr_d;
	logic [4:0]    hidx_q, hidx_d;
	logic [5:0]    bc_q, bc_d;

	logic [AW-1:0] addr, nxt;
	logic [7:0]    ent_b, ent_q;
	rec_t          r [2];
	logic [1:0]    n;

	assign addr  = byte_addr[AW-1:0];
	assign nxt   = addr + AW'(1);
	assign ent_b = OPTAB[code_byte];
	assign ent_q = OPTAB[opc_q];

	function automatic rec_t mk(input logic [1:0] kd, input logic [AW-1:0] ia,
		input logic [7:0] op, input logic [2:0] opi, input logic [3:0] md,
		input logic [3:0] rg, input logic [4:0] ix, input logic [31:0] val,
		input logic isa, input logic [5:0] len);
		rec_t x;
		begin
			x.kind             = kd;
			x.instr_addr       = 32'(ia);
			x.opcode           = op;
			x.operand_index    = opi;
			x.spec_mode        = md;
			x.base_reg         = rg;
			x.index_used       = ix[4];
			x.index_reg        = ix[4] ? ix[3:0] : 4'd0;
			x.value            = val;
			x.value_is_address = isa;
			x.length           = len;
			x.last             = 1'b0;
			return x;
		end
	endfunction

	always_comb begin
		logic [3:0]  len, total, fbl, bpos;
		logic [31:0] accn, sx;
		logic [31:0] val;
		logic        isa, fin;
		start_d = start_q; opc_d = opc_q; phase_d = phase_q; ol_d = ol_q; pos_d = pos_q;
		fbl_d = fbl_q; acc_d = acc_q; hm_d = hm_q; hr_d = hr_q; hidx_d = hidx_q; bc_d = bc_q;
		r[0] = '0; r[1] = '0; n = 2'd0;
		len = '0; total = '0; fbl = '0; bpos = '0; accn = '0; sx = '0;
		val = '0; isa = 1'b0; fin = 1'b0;
		if (restart) phase_d = PH_OPC;
		if (phase_d == PH_OPC) begin
			start_d = addr; opc_d = code_byte; bc_d = 6'd1; hidx_d = '0; pos_d = '0;
			if (!ent_b[7]) begin
				r[0] = mk(KIND_UNDEF, addr, code_byte, '0, '0, '0, '0, '0, 1'b0, 6'd1);
				n = 2'd1;
			end else begin
				ol_d = ent_b[2:0];
				if (ent_b[2:0] != 3'd0) phase_d = PH_SPEC;
				else if (ent_b[6:5] != 2'd0) begin
					phase_d = PH_BR; fbl_d = {2'b00, ent_b[6:5]}; acc_d = '0;
				end else begin
					r[0] = mk(KIND_END, addr, code_byte, '0, '0, '0, '0, '0, 1'b0, 6'd1);
					n = 2'd1;
				end
			end
		end else begin
			if (bc_q < MAX_LEN) bc_d = bc_q + 6'd1;
			if (phase_d == PH_SPEC) begin
				if (code_byte[7:4] == MODE_INDEX) begin
					hidx_d = {1'b1, code_byte[3:0]};
				end else begin
					hm_d = code_byte[7:4]; hr_d = code_byte[3:0];
					len = ext_len(code_byte[7:4], code_byte[3:0], ent_q[4:3]);
					if (len == 4'd0) begin
						fin = 1'b1;
						val = (code_byte[7:4] < MODE_INDEX) ? {26'd0, code_byte[5:0]} : 32'd0;
					end else begin
						fbl_d = len; acc_d = '0; phase_d = PH_EXT;
					end
				end
			end else begin
				total = (phase_d == PH_EXT) ? ext_len(hm_q, hr_q, ent_q[4:3])
				                            : {2'b00, ent_q[6:5]};
				fbl = (fbl_q == 4'd0 || fbl_q > total) ? total : fbl_q;
				bpos = total - fbl;
				accn = acc_q;
				if (bpos < 4'd4) accn = acc_q | (32'(code_byte) << {bpos[1:0], 3'b000});
				acc_d = accn;
				fbl_d = fbl - 4'd1;
				if (total == 4'd1)      sx = {{24{accn[7]}}, accn[7:0]};
				else if (total == 4'd2) sx = {{16{accn[15]}}, accn[15:0]};
				else                    sx = accn;
				if (fbl_d == 4'd0) begin
					if (phase_d == PH_BR) begin
						r[0] = mk(KIND_BRANCH, start_q, opc_q, '0, '0, '0, '0,
							32'(nxt + sx[AW-1:0]), 1'b1, '0);
						r[1] = mk(KIND_END, start_q, opc_q, '0, '0, '0, '0, '0, 1'b0, bc_d);
						n = 2'd2;
						phase_d = PH_OPC;
					end else begin
						fin = 1'b1;
						if (hm_q == MODE_IMM) val = accn;
						else if (hm_q == MODE_ABS) begin
							val = 32'(accn[AW-1:0]); isa = 1'b1;
						end else if (hr_q == REG_PC) begin
							val = 32'(nxt + sx[AW-1:0]); isa = 1'b1;
						end else val = sx;
					end
				end
			end
			if (fin) begin
				r[0] = mk(KIND_OPERAND, start_q, opc_q, pos_q, hm_d, hr_d, hidx_q, val, isa, '0);
				n = 2'd1;
				pos_d = pos_q + 3'd1;
				hidx_d = '0;
				ol_d = ol_q - 3'd1;
				if (ol_d != 3'd0) phase_d = PH_SPEC;
				else if (ent_q[6:5] != 2'd0) begin
					phase_d = PH_BR; fbl_d = {2'b00, ent_q[6:5]}; acc_d = '0;
				end else begin
					r[1] = mk(KIND_END, start_q, opc_q, '0, '0, '0, '0, '0, 1'b0, bc_d);
					n = 2'd2;
					phase_d = PH_OPC;
				end
			end
		end
		if (n == 2'd1) r[0].last = 1'b1;
		if (n == 2'd2) r[1].last = 1'b1;
	end

	assign rec0 = r[0];
	assign rec1 = r[1];
	assign nrec = acc ? n : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0; opc_q <= '0; phase_q <= PH_OPC; ol_q <= '0; pos_q <= '0;
			fbl_q <= '0; acc_q <= '0; hm_q <= '0; hr_q <= '0; hidx_q <= '0; bc_q <= '0;
		end else if (acc) begin
			start_q <= start_d; opc_q <= opc_d; phase_q <= phase_d; ol_q <= ol_d;
			pos_q <= pos_d; fbl_q <= fbl_d; acc_q <= acc_d; hm_q <= hm_d; hr_q <= hr_d;
			hidx_q <= hidx_d; bc_q <= bc_d;
		end
	end

endmodule

### sv/vlid_outq.sv
// ----------------------------------------------------------------------------
// vlid_outq
// Four-entry result queue taking up to two records per cycle, one out unless stalled.
// ----------------------------------------------------------------------------
module vlid_outq (
	input  logic            clk,
	input  logic            arst_n,
	input  vlid_pkg::rec_t  rec0,
	input  vlid_pkg::rec_t  rec1,
	input  logic [1:0]      nrec,
	output logic            full,
	output logic            valid,
	input  logic            stall,
	output vlid_pkg::rec_t  head
);
	import vlid_pkg::*;

	rec_t       q_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       pop;

	// Room for two records is kept so that any byte can be taken.
	assign full  = cnt_q > 3'd2;
	assign valid = cnt_q != 3'd0;
	assign head  = q_q[rp_q];
	assign pop   = valid && !stall;

	always_ff @(posedge clk) begin
		if (nrec != 2'd0) q_q[wp_q] <= rec0;
		if (nrec == 2'd2) q_q[wp_q + 2'd1] <= rec1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + nrec;
			rp_q  <= rp_q + 2'(pop);
			cnt_q <= cnt_q + 3'(nrec) - 3'(pop);
		end
	end

endmodule

### sv/variable_length_instruction_decoder.sv
// ----------------------------------------------------------------------------
// variable_length_instruction_decoder
// Byte-serial decoder of opcodes, operand specifiers and branch displacements.
// ----------------------------------------------------------------------------
// One code byte is taken per clock cycle while in_stall is low. Each byte is parsed
// in the cycle of its transfer and yields zero, one or two records, which enter a
// four-entry result queue; records leave at one per cycle while out_stall is low,
// so the byte rate is one per cycle as long as the queue drains at least as fast as
// records are made. in_stall rises while fewer than two queue entries are free.
module variable_length_instruction_decoder #(
	parameter int ADDR_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  code_byte,
	input  logic [31:0] byte_addr,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [31:0] instr_addr,
	output logic [7:0]  opcode,
	output logic [2:0]  operand_index,
	output logic [3:0]  spec_mode,
	output logic [3:0]  base_reg,
	output logic        index_used,
	output logic [3:0]  index_reg,
	output logic [31:0] value,
	output logic        value_is_address,
	output logic [5:0]  length,
	output logic        last
);
	import vlid_pkg::*;

	rec_t       rec0, rec1, head;
	logic [1:0] nrec;
	logic       full;

	assign in_stall = full;

	vlid_parse #(.ADDR_WIDTH(ADDR_WIDTH)) u_parse (
		.clk(clk), .arst_n(arst_n), .acc(in_valid && !full),
		.code_byte(code_byte), .byte_addr(byte_addr), .restart(restart),
		.rec0(rec0), .rec1(rec1), .nrec(nrec)
	);

	vlid_outq u_outq (
		.clk(clk), .arst_n(arst_n), .rec0(rec0), .rec1(rec1), .nrec(nrec),
		.full(full), .valid(out_valid), .stall(out_stall), .head(head)
	);

	assign kind             = head.kind;
	assign instr_addr       = head.instr_addr;
	assign opcode           = head.opcode;
	assign operand_index    = head.operand_index;
	assign spec_mode        = head.spec_mode;
	assign base_reg         = head.base_reg;
	assign index_used       = head.index_used;
	assign index_reg        = head.index_reg;
	assign value            = head.value;
	assign value_is_address = head.value_is_address;
	assign length           = head.length;
	assign last             = head.last;

endmodule
